[src/log_record_deframer_checker_assert.svh]
// Assertion macros for the log record deframer and checker.
`ifndef LOG_RECORD_DEFRAMER_CHECKER_ASSERT_SVH
`define LOG_RECORD_DEFRAMER_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRDC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lrdc_pkg.sv]
// Shared types, codes and constants of the log record deframer and checker.
`timescale 1ns / 1ps

package lrdc_pkg;

    localparam logic [31:0] RECORD_MAGIC = 32'h4b56574c;
    localparam logic [31:0] FNV_BASIS    = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME    = 32'd16777619;

    localparam int unsigned RECORD_HDR_LEN = 20;
    localparam int unsigned HDR_IDX_W      = $clog2(RECORD_HDR_LEN);
    localparam int unsigned CFG_INDEX_W    = 2;
    localparam int unsigned TAIL_W         = 34;

    localparam logic [CFG_INDEX_W-1:0] CFG_PUT_TYPE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELETE_TYPE = 2'd1;

    localparam logic [7:0] PUT_TYPE_RESET    = 8'd0;
    localparam logic [7:0] DELETE_TYPE_RESET = 8'd1;

    localparam logic [2:0] KIND_KEY_BYTE    = 3'd0;
    localparam logic [2:0] KIND_VALUE_BYTE  = 3'd1;
    localparam logic [2:0] KIND_EMPTY_CLOSE = 3'd2;
    localparam logic [2:0] KIND_SUMMARY     = 3'd3;
    localparam logic [2:0] KIND_ERROR       = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
    localparam logic [1:0] STATUS_BAD_TYPE  = 2'd2;
    localparam logic [1:0] STATUS_MISMATCH  = 2'd3;

    typedef struct packed {
        logic [2:0]        result_kind;
        logic [7:0]        payload_byte;
        logic              record_closes;
        logic [1:0]        status_code;
        logic [7:0]        kind_of_record;
        logic [31:0]       key_bytes_total;
        logic [31:0]       value_bytes_total;
        logic [31:0]       records_applied;
        logic [TAIL_W-1:0] tail_skipped;
    } lrdc_result_t;

    typedef struct packed {
        logic                   write;
        logic [CFG_INDEX_W-1:0] index;
        logic [7:0]             data;
    } lrdc_cfg_wr_t;

    typedef struct packed {
        logic has_result;
        logic halted;
    } lrdc_status_t;

    // One FNV-1a step: fold the byte in, then multiply by the prime modulo 2^32.
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

[src/lrdc_engine.sv]
// Record state, header decoding, checksum and result generation for one item.
`timescale 1ns / 1ps

module lrdc_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            stream_byte,
    input  logic                  end_of_stream,
    input  lrdc_pkg::lrdc_cfg_wr_t cfg_wr,
    output lrdc_pkg::lrdc_result_t result,
    output lrdc_pkg::lrdc_status_t status
);
    import lrdc_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_KEY,
        PH_VALUE
    } phase_t;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(RECORD_HDR_LEN - 1);

    phase_t                phase_reg, phase_next;
    logic [HDR_IDX_W-1:0]  hidx_reg, hidx_next;
    logic [31:0]           magic_reg, magic_next;
    logic [7:0]            type_reg, type_next;
    logic [31:0]           key_len_reg, key_len_next;
    logic [31:0]           value_len_reg, value_len_next;
    logic [31:0]           cksum_reg, cksum_next;
    logic [31:0]           pcount_reg, pcount_next;
    logic [31:0]           hash_reg, hash_next;
    logic [31:0]           applied_reg, applied_next;
    logic [TAIL_W-1:0]     rbc_reg, rbc_next;
    logic                  halted_reg, halted_next;
    logic [7:0]            put_type_reg, delete_type_reg;

    logic [31:0] hash_step;
    logic [31:0] pcount_inc;
    logic        emit;
    logic        close;
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  code;
    logic        closes;

    assign hash_step  = fnv_step(hash_reg, stream_byte);
    assign pcount_inc = pcount_reg + 32'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        hidx_next      = hidx_reg;
        magic_next     = magic_reg;
        type_next      = type_reg;
        key_len_next   = key_len_reg;
        value_len_next = value_len_reg;
        cksum_next     = cksum_reg;
        pcount_next    = pcount_reg;
        hash_next      = hash_reg;
        applied_next   = applied_reg;
        rbc_next       = rbc_reg;
        halted_next    = halted_reg;
        emit           = 1'b0;
        close          = 1'b0;
        kind           = KIND_KEY_BYTE;
        out_byte       = 8'd0;
        code           = STATUS_OK;
        closes         = 1'b0;

        if (!halted_reg && end_of_stream)
        begin
            emit = 1'b1;
            kind = KIND_SUMMARY;
        end
        else if (!halted_reg)
        begin
            rbc_next = rbc_reg + TAIL_W'(1);
            case (phase_reg)
                PH_HEADER:
                begin
                    if (hidx_reg < HDR_IDX_W'(4))
                    begin
                        magic_next = {stream_byte, magic_reg[31:8]};
                    end
                    else if (hidx_reg == HDR_IDX_W'(4))
                    begin
                        type_next = stream_byte;
                        hash_next = hash_step;
                    end
                    else if (hidx_reg >= HDR_IDX_W'(8) && hidx_reg < HDR_IDX_W'(12))
                    begin
                        key_len_next = {stream_byte, key_len_reg[31:8]};
                        hash_next    = hash_step;
                    end
                    else if (hidx_reg >= HDR_IDX_W'(12) && hidx_reg < HDR_IDX_W'(16))
                    begin
                        value_len_next = {stream_byte, value_len_reg[31:8]};
                        hash_next      = hash_step;
                    end
                    else if (hidx_reg >= HDR_IDX_W'(16))
                    begin
                        cksum_next = {stream_byte, cksum_reg[31:8]};
                    end

                    if (hidx_reg != HDR_LAST)
                    begin
                        hidx_next = hidx_reg + HDR_IDX_W'(1);
                    end
                    else
                    begin
                        hidx_next = '0;
                        if (magic_next != RECORD_MAGIC)
                        begin
                            halted_next = 1'b1;
                            emit        = 1'b1;
                            kind        = KIND_ERROR;
                            code        = STATUS_BAD_MAGIC;
                        end
                        else if (type_next != put_type_reg && type_next != delete_type_reg)
                        begin
                            halted_next = 1'b1;
                            emit        = 1'b1;
                            kind        = KIND_ERROR;
                            code        = STATUS_BAD_TYPE;
                        end
                        else
                        begin
                            pcount_next = '0;
                            if (key_len_next != 32'd0)
                            begin
                                phase_next = PH_KEY;
                            end
                            else if (value_len_next != 32'd0)
                            begin
                                phase_next = PH_VALUE;
                            end
                            else
                            begin
                                close = 1'b1;
                                kind  = KIND_EMPTY_CLOSE;
                            end
                        end
                    end
                end
                PH_KEY:
                begin
                    hash_next   = hash_step;
                    pcount_next = pcount_inc;
                    emit        = 1'b1;
                    kind        = KIND_KEY_BYTE;
                    out_byte    = stream_byte;
                    if (pcount_inc == key_len_reg)
                    begin
                        pcount_next = '0;
                        if (value_len_reg != 32'd0)
                        begin
                            phase_next = PH_VALUE;
                        end
                        else
                        begin
                            close = 1'b1;
                        end
                    end
                end
                PH_VALUE:
                begin
                    hash_next   = hash_step;
                    pcount_next = pcount_inc;
                    emit        = 1'b1;
                    kind        = KIND_VALUE_BYTE;
                    out_byte    = stream_byte;
                    if (pcount_inc == value_len_reg)
                    begin
                        close = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase

            // The end of a record compares the finished hash with the stored checksum.
            if (close)
            begin
                emit   = 1'b1;
                closes = 1'b1;
                if (hash_next == cksum_next)
                begin
                    if (applied_reg != 32'hffffffff)
                    begin
                        applied_next = applied_reg + 32'd1;
                    end
                    phase_next  = PH_HEADER;
                    hidx_next   = '0;
                    pcount_next = '0;
                    hash_next   = FNV_BASIS;
                    rbc_next    = '0;
                end
                else
                begin
                    halted_next = 1'b1;
                    kind        = KIND_ERROR;
                    code        = STATUS_MISMATCH;
                end
            end
        end
    end

    always_comb
    begin
        result.result_kind    = kind;
        result.payload_byte   = out_byte;
        result.record_closes  = closes;
        result.status_code    = code;
        result.records_applied = applied_next;
        if (kind == KIND_SUMMARY)
        begin
            result.kind_of_record    = 8'd0;
            result.key_bytes_total   = 32'd0;
            result.value_bytes_total = 32'd0;
            result.tail_skipped      = rbc_reg;
        end
        else
        begin
            result.kind_of_record    = type_next;
            result.key_bytes_total   = key_len_next;
            result.value_bytes_total = value_len_next;
            result.tail_skipped      = '0;
        end
    end

    assign status.has_result = emit;
    assign status.halted     = halted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            put_type_reg    <= PUT_TYPE_RESET;
            delete_type_reg <= DELETE_TYPE_RESET;
        end
        else if (cfg_wr.write)
        begin
            if (cfg_wr.index == CFG_PUT_TYPE)
            begin
                put_type_reg <= cfg_wr.data;
            end
            else if (cfg_wr.index == CFG_DELETE_TYPE)
            begin
                delete_type_reg <= cfg_wr.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hidx_reg      <= '0;
            magic_reg     <= '0;
            type_reg      <= '0;
            key_len_reg   <= '0;
            value_len_reg <= '0;
            cksum_reg     <= '0;
            pcount_reg    <= '0;
            hash_reg      <= FNV_BASIS;
            applied_reg   <= '0;
            rbc_reg       <= '0;
            halted_reg    <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            hidx_reg      <= hidx_next;
            magic_reg     <= magic_next;
            type_reg      <= type_next;
            key_len_reg   <= key_len_next;
            value_len_reg <= value_len_next;
            cksum_reg     <= cksum_next;
            pcount_reg    <= pcount_next;
            hash_reg      <= hash_next;
            applied_reg   <= applied_next;
            rbc_reg       <= rbc_next;
            halted_reg    <= halted_next;
        end
    end

endmodule

[src/log_record_deframer_checker.sv]
// Top level of the log record deframer and checker: item buffers and handshakes.
`timescale 1ns / 1ps
`include "log_record_deframer_checker_assert.svh"

// The block takes one log stream byte per item and can accept a new item in every clock
// cycle, sustaining one byte per cycle while results are taken. An accepted item is held
// in an input register, processed by combinational logic (header decode, at most one FNV-1a
// step and the checksum compare) and any result is placed in an output register, from which
// it is presented. The rate is set by the running hash, which must be updated for one byte
// before the next can be folded in. Configuration writes are taken in any cycle and must
// only be made while the block is idle; errors halt the block until reset.
module log_record_deframer_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [7:0]                        stream_byte,
    input  logic                              end_of_stream,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [2:0]                        result_kind,
    output logic [7:0]                        payload_byte,
    output logic                              record_closes,
    output logic [1:0]                        status_code,
    output logic [7:0]                        kind_of_record,
    output logic [31:0]                       key_bytes_total,
    output logic [31:0]                       value_bytes_total,
    output logic [31:0]                       records_applied,
    output logic [lrdc_pkg::TAIL_W-1:0]       tail_skipped,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                        cfg_data
);
    import lrdc_pkg::*;

    logic         item_valid_reg;
    logic [7:0]   byte_reg;
    logic         eos_reg;
    logic         result_valid_reg;
    lrdc_result_t result_reg;
    lrdc_result_t eng_result;
    lrdc_status_t eng_status;
    lrdc_cfg_wr_t cfg_wr;
    logic         fire;

    assign fire       = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || fire;
    assign cfg_ready  = 1'b1;

    assign cfg_wr.write = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    lrdc_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .stream_byte   (byte_reg),
        .end_of_stream (eos_reg),
        .cfg_wr        (cfg_wr),
        .result        (eng_result),
        .status        (eng_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            byte_reg <= stream_byte;
            eos_reg  <= end_of_stream;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            result_valid_reg <= eng_status.has_result;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && eng_status.has_result)
        begin
            result_reg <= eng_result;
        end
    end

    assign result_valid      = result_valid_reg;
    assign result_kind       = result_reg.result_kind;
    assign payload_byte      = result_reg.payload_byte;
    assign record_closes     = result_reg.record_closes;
    assign status_code       = result_reg.status_code;
    assign kind_of_record    = result_reg.kind_of_record;
    assign key_bytes_total   = result_reg.key_bytes_total;
    assign value_bytes_total = result_reg.value_bytes_total;
    assign records_applied   = result_reg.records_applied;
    assign tail_skipped      = result_reg.tail_skipped;

    `LRDC_ASSERT_SAME(a_halted_silent, fire && eng_status.halted, !eng_status.has_result, "result produced while halted")
    `LRDC_ASSERT_NEXT(a_error_halts, fire && eng_status.has_result && eng_result.result_kind == KIND_ERROR, eng_status.halted, "error result did not halt the block")
    `LRDC_ASSERT_NEXT(a_buffer_holds, item_valid_reg && !fire, item_valid_reg && $stable(byte_reg) && $stable(eos_reg), "buffered item lost while stalled")

endmodule
